@@ design/assert_macros.svh @@
// Assertion macros shared by the SIR event engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIRG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SIRG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/sirg_pkg.sv @@
// Types and constants of the network SIR Gillespie event engine.
`timescale 1ns / 1ps

package sirg_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int MAX_DEGREE_DEF = 16;

  localparam int NODE_W     = 10;
  localparam int SLOT_W     = 4;
  localparam int DEG_W      = 5;
  localparam int STAT_W     = 2;
  localparam int RATE_W     = 32;
  localparam int UNI_W      = 32;
  localparam int TIME_W     = 48;
  localparam int FRAC_SH    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int NIU_W      = 11;
  localparam int DIV_STEPS  = 48;
  localparam int DIV_CNT_W  = 6;

  // Node status codes
  localparam logic [STAT_W-1:0] STAT_S = 2'd0;
  localparam logic [STAT_W-1:0] STAT_I = 2'd1;
  localparam logic [STAT_W-1:0] STAT_R = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INFECT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TLIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN     = 3'd5;

  typedef enum logic [1:0] {
    MODE_LOAD_NODE,
    MODE_LOAD_NBR,
    MODE_SIMULATE,
    MODE_READ
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_INFECT,
    KIND_RECOVER,
    KIND_STOP
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_READW,
    S_SUM,
    S_THR1,
    S_THR2,
    S_SEL,
    S_DIVW,
    S_EVENT,
    S_WADJ,
    S_WADJW,
    S_WNB,
    S_KPICK,
    S_PADJ,
    S_PADJW,
    S_PNB,
    S_FIN
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [NODE_W-1:0]   node;
    logic [SLOT_W-1:0]   slot;
    logic [NODE_W-1:0]   neighbor;
    logic [DEG_W-1:0]    degree;
    logic [STAT_W-1:0]   status_in;
    logic [RATE_W-1:0]   rate_in;
    logic [UNI_W-1:0]    pick_uniform;
    logic [UNI_W-1:0]    wait_variate;
    logic [UNI_W-1:0]    infector_uniform;
  } in_t;

  typedef struct packed {
    kind_e               event_kind;
    logic [NODE_W-1:0]   event_node;
    logic [TIME_W-1:0]   event_time;
    logic [DEG_W-1:0]    susceptible_neighbors;
    logic [NODE_W-1:0]   chosen_infector;
    logic                infector_valid;
    logic [STAT_W-1:0]   status_out;
    logic [RATE_W-1:0]   rate_out;
  } out_t;

  // One entry of the node memory
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [RATE_W-1:0] rate;
    logic [DEG_W-1:0]  degree;
  } node_word_t;

endpackage

@@ design/network_sir_gillespie_step.sv @@
// Top level: network SIR Gillespie direct-method event engine.
`timescale 1ns / 1ps
// Load node / load neighbor requests write memory in S_EXEC; read node adds S_READW.
// Simulate: two rate scans (S_SUM, S_SEL) over the node memory's single read port, then
// a neighbor walk, plus a second walk on a tracked infection with infected neighbors;
// the divider runs alongside the second scan.
// One request at a time; a finished result waits in the output register.
// Reset clears control and time, presets config; node/neighbor memories undefined until loaded.

`include "assert_macros.svh"

module network_sir_gillespie_step #(
  parameter int NODE_COUNT = sirg_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = sirg_pkg::MAX_DEGREE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sirg_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sirg_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sirg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sirg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int AW        = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);
  localparam int TW        = sirg_pkg::RATE_W + AW;
  localparam int THR_W     = TW + 1;
  localparam int SLC_W     = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_DEPTH = NODE_COUNT * MAX_DEGREE;
  localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
  localparam int KP_W      = sirg_pkg::UNI_W + SLC_W;
  localparam int RW        = sirg_pkg::RATE_W;
  localparam int TMW       = sirg_pkg::TIME_W;

  // Configuration registers
  logic [RW-1:0]                 infect_q, recover_q;
  logic [TMW-1:0]                tlimit_q;
  logic                          track_q, run_q;
  logic [sirg_pkg::NIU_W-1:0]    nodes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infect_q  <= RW'(65536);
      recover_q <= RW'(65536);
      tlimit_q  <= '0;
      track_q   <= 1'b0;
      nodes_q   <= sirg_pkg::NIU_W'(1024);
      run_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sirg_pkg::CFG_INFECT:  infect_q  <= cfg_data_i[RW-1:0];
        sirg_pkg::CFG_RECOVER: recover_q <= cfg_data_i[RW-1:0];
        sirg_pkg::CFG_TLIMIT:  tlimit_q  <= cfg_data_i[TMW-1:0];
        sirg_pkg::CFG_TRACK:   track_q   <= cfg_data_i[0];
        sirg_pkg::CFG_NODES:   nodes_q   <= cfg_data_i[sirg_pkg::NIU_W-1:0];
        sirg_pkg::CFG_RUN:     run_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Memories
  sirg_pkg::node_word_t               node_mem [NODE_COUNT];
  logic [sirg_pkg::NODE_W-1:0]        adj_mem  [ADJ_DEPTH];
  sirg_pkg::node_word_t               node_rd_q;
  logic [sirg_pkg::NODE_W-1:0]        adj_rd_q;

  logic                               node_we, node_re, adj_we, adj_re;
  logic [AW-1:0]                      node_waddr, node_raddr;
  sirg_pkg::node_word_t               node_wdata;
  logic [ADJ_AW-1:0]                  adj_waddr, adj_raddr;
  logic [sirg_pkg::NODE_W-1:0]        adj_wdata;

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) adj_rd_q <= adj_mem[adj_raddr];
  end

  // Control and datapath registers
  sirg_pkg::state_e                   state_q, state_d;
  sirg_pkg::in_t                      req_q, req_d;
  sirg_pkg::out_t                     res_q, res_d;
  sirg_pkg::out_t                     out_data_q;
  logic                               out_valid_q;
  logic [CNT_W-1:0]                   idx_q, idx_d;
  logic                               rv_q, rv_d;
  logic [AW-1:0]                      ridx_q, ridx_d, ev_q, ev_d;
  logic [TW-1:0]                      total_q, total_d, cum_q, cum_d;
  logic [THR_W-1:0]                   thr_q, thr_d;
  logic [2*RW-1:0]                    lowp_q, lowp_d;
  sirg_pkg::node_word_t               evw_q, evw_d;
  logic [sirg_pkg::STAT_W-1:0]        snew_q, snew_d;
  logic [SLC_W-1:0]                   deg_q, deg_d, slot_q, slot_d;
  logic [SLC_W-1:0]                   contacts_q, contacts_d, infk_q, infk_d;
  logic [SLC_W-1:0]                   k_q, k_d, seen_q, seen_d;
  logic [TMW-1:0]                     time_q, time_d;
  logic                               stopped_q, stopped_d;

  // Divider registers
  logic                               div_busy_q;
  logic [sirg_pkg::DIV_CNT_W-1:0]     div_cnt_q;
  logic [TW-1:0]                      div_rem_q;
  logic [TMW-1:0]                     div_dvd_q;

  // Shared conditions
  logic [CNT_W-1:0]                   n_cnt;
  logic                               scan_more, scan_done, sel_hit, stop_now, out_free;
  logic [TW-1:0]                      cum_new;
  logic [sirg_pkg::STAT_W-1:0]        stat_inc;
  logic                               nb_ok, req_node_ok, req_slot_ok;
  logic [ADJ_AW-1:0]                  walk_addr;
  logic [KP_W-1:0]                    kprod;
  logic [SLC_W-1:0]                   k_raw;
  logic [TMW:0]                       time_sum;
  logic [RW:0]                        rate_add;
  logic [RW-1:0]                      rate_mod;

  assign n_cnt = (32'(nodes_q) > 32'(NODE_COUNT)) ? CNT_W'(NODE_COUNT) : CNT_W'(nodes_q);
  assign scan_more = (idx_q < n_cnt);
  assign scan_done = !scan_more && !rv_q;
  assign cum_new   = cum_q + TW'(node_rd_q.rate);
  assign sel_hit   = rv_q && ({1'b0, cum_new} >= thr_q);
  assign stop_now  = stopped_q || !run_q || (time_q >= tlimit_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign stat_inc  = (evw_q.status >= sirg_pkg::STAT_R) ? sirg_pkg::STAT_R
                                                         : evw_q.status + 2'd1;
  assign nb_ok       = (32'(adj_rd_q) < 32'(NODE_COUNT));
  assign req_node_ok = (32'(req_q.node) < 32'(NODE_COUNT));
  assign req_slot_ok = (32'(req_q.slot) < 32'(MAX_DEGREE));
  assign walk_addr   = ADJ_AW'(ev_q) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(slot_q);
  assign kprod       = KP_W'(req_q.infector_uniform) * KP_W'(infk_q);
  assign k_raw       = kprod[KP_W-1:sirg_pkg::UNI_W];
  assign time_sum    = {1'b0, time_q} + {1'b0, div_dvd_q};
  assign rate_add    = {1'b0, node_rd_q.rate} + {1'b0, infect_q};

  // Neighbor rate update: saturating add on infection, subtract on recovery
  always_comb begin
    if (snew_q == sirg_pkg::STAT_R) begin
      rate_mod = (node_rd_q.rate > infect_q) ? node_rd_q.rate - infect_q : '0;
    end else begin
      rate_mod = rate_add[RW] ? '1 : rate_add[RW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sirg_pkg::S_IDLE: if (in_valid_i) state_d = sirg_pkg::S_EXEC;
      sirg_pkg::S_EXEC: begin
        case (req_q.mode)
          sirg_pkg::MODE_SIMULATE: state_d = stop_now ? sirg_pkg::S_FIN : sirg_pkg::S_SUM;
          sirg_pkg::MODE_READ:     state_d = req_node_ok ? sirg_pkg::S_READW
                                                         : sirg_pkg::S_FIN;
          default:                 state_d = sirg_pkg::S_FIN;
        endcase
      end
      sirg_pkg::S_READW: state_d = sirg_pkg::S_FIN;
      sirg_pkg::S_SUM: begin
        if (scan_done) state_d = (total_q == '0) ? sirg_pkg::S_FIN : sirg_pkg::S_THR1;
      end
      sirg_pkg::S_THR1: state_d = sirg_pkg::S_THR2;
      sirg_pkg::S_THR2: state_d = sirg_pkg::S_SEL;
      sirg_pkg::S_SEL:  if (sel_hit || scan_done) state_d = sirg_pkg::S_DIVW;
      sirg_pkg::S_DIVW: if (!div_busy_q) state_d = sirg_pkg::S_EVENT;
      sirg_pkg::S_EVENT: state_d = sirg_pkg::S_WADJ;
      sirg_pkg::S_WADJ: begin
        if (slot_q < deg_q) begin
          state_d = sirg_pkg::S_WADJW;
        end else if (snew_q == sirg_pkg::STAT_I && track_q && infk_q != '0) begin
          state_d = sirg_pkg::S_KPICK;
        end else begin
          state_d = sirg_pkg::S_FIN;
        end
      end
      sirg_pkg::S_WADJW: state_d = nb_ok ? sirg_pkg::S_WNB : sirg_pkg::S_WADJ;
      sirg_pkg::S_WNB:   state_d = sirg_pkg::S_WADJ;
      sirg_pkg::S_KPICK: state_d = sirg_pkg::S_PADJ;
      sirg_pkg::S_PADJ:  state_d = (slot_q < deg_q) ? sirg_pkg::S_PADJW : sirg_pkg::S_FIN;
      sirg_pkg::S_PADJW: state_d = nb_ok ? sirg_pkg::S_PNB : sirg_pkg::S_PADJ;
      sirg_pkg::S_PNB: begin
        if (node_rd_q.status == sirg_pkg::STAT_I && seen_q == k_q) begin
          state_d = sirg_pkg::S_FIN;
        end else begin
          state_d = sirg_pkg::S_PADJ;
        end
      end
      sirg_pkg::S_FIN: if (out_free) state_d = sirg_pkg::S_IDLE;
      default: state_d = sirg_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    req_d      = req_q;
    res_d      = res_q;
    idx_d      = idx_q;
    rv_d       = rv_q;
    ridx_d     = ridx_q;
    ev_d       = ev_q;
    total_d    = total_q;
    cum_d      = cum_q;
    thr_d      = thr_q;
    lowp_d     = lowp_q;
    evw_d      = evw_q;
    snew_d     = snew_q;
    deg_d      = deg_q;
    slot_d     = slot_q;
    contacts_d = contacts_q;
    infk_d     = infk_q;
    k_d        = k_q;
    seen_d     = seen_q;
    time_d     = time_q;
    stopped_d  = stopped_q;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_waddr = ev_q;
    node_raddr = idx_q[AW-1:0];
    node_wdata = evw_q;
    adj_we     = 1'b0;
    adj_re     = 1'b0;
    adj_waddr  = ADJ_AW'(req_q.node) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(req_q.slot);
    adj_raddr  = walk_addr;
    adj_wdata  = req_q.neighbor;

    case (state_q)
      sirg_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          res_d = '0;
          res_d.event_node = in_data_i.node;
        end
      end

      sirg_pkg::S_EXEC: begin
        idx_d   = '0;
        rv_d    = 1'b0;
        total_d = '0;
        case (req_q.mode)
          sirg_pkg::MODE_LOAD_NODE: begin
            node_we    = req_node_ok;
            node_waddr = AW'(req_q.node);
            node_wdata.status = (req_q.status_in > sirg_pkg::STAT_R) ? sirg_pkg::STAT_R
                                                                     : req_q.status_in;
            node_wdata.rate   = req_q.rate_in;
            node_wdata.degree = (32'(req_q.degree) > 32'(MAX_DEGREE))
                                ? sirg_pkg::DEG_W'(MAX_DEGREE) : req_q.degree;
          end
          sirg_pkg::MODE_LOAD_NBR: begin
            adj_we = req_node_ok && req_slot_ok;
          end
          sirg_pkg::MODE_READ: begin
            node_re    = req_node_ok;
            node_raddr = AW'(req_q.node);
          end
          default: begin
            // simulate: a stop is decided before any scan
            if (stop_now) begin
              stopped_d        = 1'b1;
              res_d.event_kind = sirg_pkg::KIND_STOP;
              res_d.event_node = '0;
              res_d.event_time = track_q ? time_q : '0;
            end
          end
        endcase
      end

      sirg_pkg::S_READW: begin
        res_d.status_out = node_rd_q.status;
        res_d.rate_out   = node_rd_q.rate;
      end

      // First scan: rate total
      sirg_pkg::S_SUM: begin
        node_re = scan_more;
        rv_d    = scan_more;
        ridx_d  = idx_q[AW-1:0];
        if (scan_more) idx_d = idx_q + 1'b1;
        if (rv_q) total_d = total_q + TW'(node_rd_q.rate);
        if (scan_done && total_q == '0) begin
          stopped_d        = 1'b1;
          res_d.event_kind = sirg_pkg::KIND_STOP;
          res_d.event_node = '0;
          res_d.event_time = track_q ? time_q : '0;
        end
      end

      // Threshold ceil(u * total), split in two products
      sirg_pkg::S_THR1: begin
        lowp_d = (2*RW)'(req_q.pick_uniform) * (2*RW)'(total_q[RW-1:0]);
      end
      sirg_pkg::S_THR2: begin
        thr_d = THR_W'(THR_W'(req_q.pick_uniform) * THR_W'(total_q[TW-1:RW]))
              + THR_W'(lowp_q[2*RW-1:RW]) + THR_W'(lowp_q[RW-1:0] != '0);
        idx_d = '0;
        rv_d  = 1'b0;
        cum_d = '0;
      end

      // Second scan: first node whose running sum reaches the threshold
      sirg_pkg::S_SEL: begin
        node_re = scan_more && !sel_hit;
        rv_d    = scan_more && !sel_hit;
        ridx_d  = idx_q[AW-1:0];
        if (scan_more) idx_d = idx_q + 1'b1;
        if (rv_q) begin
          cum_d = cum_new;
          ev_d  = ridx_q;
          evw_d = node_rd_q;
        end
      end

      sirg_pkg::S_DIVW: ;

      // Event node update and time step
      sirg_pkg::S_EVENT: begin
        node_we    = 1'b1;
        node_waddr = ev_q;
        node_wdata.status = stat_inc;
        node_wdata.rate   = (stat_inc == sirg_pkg::STAT_R) ? '0 : recover_q;
        node_wdata.degree = evw_q.degree;
        snew_d = stat_inc;
        deg_d  = (32'(evw_q.degree) > 32'(MAX_DEGREE)) ? SLC_W'(MAX_DEGREE)
                                                       : SLC_W'(evw_q.degree);
        time_d = time_sum[TMW] ? '1 : time_sum[TMW-1:0];
        slot_d     = '0;
        contacts_d = '0;
        infk_d     = '0;
        res_d.event_kind = (stat_inc == sirg_pkg::STAT_R) ? sirg_pkg::KIND_RECOVER
                                                          : sirg_pkg::KIND_INFECT;
        res_d.event_node = sirg_pkg::NODE_W'(ev_q);
        res_d.event_time = track_q ? (time_sum[TMW] ? '1 : time_sum[TMW-1:0]) : '0;
      end

      // Neighbor walk: one slot per read-modify-write
      sirg_pkg::S_WADJ: begin
        adj_re = (slot_q < deg_q);
        if (slot_q >= deg_q && snew_q == sirg_pkg::STAT_I && track_q) begin
          res_d.susceptible_neighbors = sirg_pkg::DEG_W'(contacts_q);
        end
      end
      sirg_pkg::S_WADJW, sirg_pkg::S_PADJW: begin
        node_re    = nb_ok;
        node_raddr = AW'(adj_rd_q);
        if (!nb_ok) slot_d = slot_q + 1'b1;
      end
      sirg_pkg::S_WNB: begin
        slot_d = slot_q + 1'b1;
        if (node_rd_q.status == sirg_pkg::STAT_S) begin
          contacts_d      = contacts_q + 1'b1;
          node_we         = 1'b1;
          node_waddr      = AW'(adj_rd_q);
          node_wdata      = node_rd_q;
          node_wdata.rate = rate_mod;
        end else if (node_rd_q.status == sirg_pkg::STAT_I) begin
          infk_d = infk_q + 1'b1;
        end
      end

      // Infector pick: second walk counts infected neighbors up to entry k
      sirg_pkg::S_KPICK: begin
        k_d    = (k_raw >= infk_q) ? infk_q - 1'b1 : k_raw;
        seen_d = '0;
        slot_d = '0;
      end
      sirg_pkg::S_PADJ: adj_re = (slot_q < deg_q);
      sirg_pkg::S_PNB: begin
        slot_d = slot_q + 1'b1;
        if (node_rd_q.status == sirg_pkg::STAT_I) begin
          seen_d = seen_q + 1'b1;
          if (seen_q == k_q) begin
            res_d.chosen_infector = adj_rd_q;
            res_d.infector_valid  = 1'b1;
          end
        end
      end

      sirg_pkg::S_FIN: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sirg_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      time_q      <= '0;
      stopped_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rv_q      <= rv_d;
      time_q    <= time_d;
      stopped_q <= stopped_d;
      if (state_q == sirg_pkg::S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    idx_q      <= idx_d;
    ridx_q     <= ridx_d;
    ev_q       <= ev_d;
    total_q    <= total_d;
    cum_q      <= cum_d;
    thr_q      <= thr_d;
    lowp_q     <= lowp_d;
    evw_q      <= evw_d;
    snew_q     <= snew_d;
    deg_q      <= deg_d;
    slot_q     <= slot_d;
    contacts_q <= contacts_d;
    infk_q     <= infk_d;
    k_q        <= k_d;
    seen_q     <= seen_d;
    if (state_q == sirg_pkg::S_FIN && out_free) out_data_q <= res_q;
  end

  // Restoring divider: (wait_variate << 16) / total, one quotient bit a cycle
  logic [TW:0] div_sh;
  logic        div_ge;

  assign div_sh = {div_rem_q, div_dvd_q[TMW-1]};
  assign div_ge = (div_sh >= {1'b0, total_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (state_q == sirg_pkg::S_THR1) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= sirg_pkg::DIV_CNT_W'(sirg_pkg::DIV_STEPS);
    end else if (div_busy_q) begin
      div_cnt_q  <= div_cnt_q - 1'b1;
      div_busy_q <= (div_cnt_q != sirg_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sirg_pkg::S_THR1) begin
      div_rem_q <= '0;
      div_dvd_q <= {req_q.wait_variate, sirg_pkg::FRAC_SH'(0)};
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? TW'(div_sh - {1'b0, total_q}) : TW'(div_sh);
      div_dvd_q <= {div_dvd_q[TMW-2:0], div_ge};
    end
  end

  assign in_stall_o  = (state_q != sirg_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `SIRG_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)
  `SIRG_ASSERT_NXT(a_stop_sticky, stopped_q, stopped_q)
  `SIRG_ASSERT_IMP(a_out_from_fin, $rose(out_valid_o), $past(state_q == sirg_pkg::S_FIN))
  `SIRG_ASSERT_IMP(a_div_done, state_q == sirg_pkg::S_EVENT, !div_busy_q)

endmodule
